// File: sv/tpi_pkg.sv
// Shared constants, codes and item types of the tabulated potential interpolator.
`timescale 1ns / 1ps

package tpi_pkg;

	// Default table depth in 32-bit words, low guard word included
	localparam int TPI_TABLE_WORDS = 4096;
	// Entries of the queue between front and back
	localparam int TPI_QUEUE_DEPTH = 4;
	localparam int TPI_INDEX_W = 12;
	localparam int TPI_WORD_W = 32;
	localparam int TPI_CFG_INDEX_W = 2;
	// inverse_step after reset: 1.0 in Q16.16
	localparam logic [TPI_WORD_W-1:0] TPI_INV_STEP_RESET = 32'h0001_0000;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [TPI_CFG_INDEX_W-1:0] {
		CFG_TABLE_START  = 2'd0,
		CFG_TABLE_END    = 2'd1,
		CFG_INVERSE_STEP = 2'd2
	} cfg_index_t;

	// Input transfer
	typedef struct packed {
		op_t                          operation;
		logic [TPI_INDEX_W-1:0]       entry_index;
		logic signed [TPI_WORD_W-1:0] entry_value;
		logic signed [TPI_WORD_W-1:0] distance;
	} in_item_t;

	// Result transfer
	typedef struct packed {
		logic signed [TPI_WORD_W-1:0] interpolated_value;
		logic signed [TPI_WORD_W-1:0] slope;
		logic                         index_saturated;
	} out_item_t;

	// Classified item held in the queue
	typedef struct packed {
		op_t                    operation;
		logic [TPI_INDEX_W-1:0] entry_index;
		logic [TPI_WORD_W-1:0]  entry_value;
		// clamped distance minus table_start, zero when not positive
		logic [TPI_WORD_W-1:0]  offset;
	} q_item_t;

endpackage

// File: sv/tpi_front.sv
// Front stage: accepts items, clamps the query distance and forms its offset.
`timescale 1ns / 1ps

module tpi_front import tpi_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  in_item_t                     in_data,
	input  logic signed [TPI_WORD_W-1:0] table_start,
	input  logic signed [TPI_WORD_W-1:0] table_end,
	output logic                         item_valid,
	input  logic                         item_ready,
	output q_item_t                      item
);

	logic                         vld_q;
	q_item_t                      item_q;
	logic                         accept;
	logic signed [TPI_WORD_W-1:0] clamped;
	logic signed [TPI_WORD_W:0]   offset_full;
	q_item_t                      item_next;

	assign in_stall   = vld_q && !item_ready;
	assign accept     = in_valid && !in_stall;
	assign item_valid = vld_q;
	assign item       = item_q;

	// Clamp to [table_start, table_end]; a non-positive offset means index and fraction zero
	always_comb begin
		priority if (in_data.distance < table_start) begin
			clamped = table_start;
		end else if (in_data.distance > table_end) begin
			clamped = table_end;
		end else begin
			clamped = in_data.distance;
		end
		offset_full = (TPI_WORD_W+1)'(clamped) - (TPI_WORD_W+1)'(table_start);
		item_next.operation   = in_data.operation;
		item_next.entry_index = in_data.entry_index;
		item_next.entry_value = in_data.entry_value;
		item_next.offset      = (offset_full > 0) ? offset_full[TPI_WORD_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (accept) begin
			vld_q <= 1'b1;
		end else if (item_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item_next;
		end
	end

endmodule

// File: sv/tpi_fifo.sv
// Short queue that decouples the front stage from the back pipeline.
`timescale 1ns / 1ps

module tpi_fifo import tpi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  q_item_t push_item,
	output logic    pop_valid,
	input  logic    pop_ready,
	output q_item_t pop_item
);

	localparam int PW = $clog2(TPI_QUEUE_DEPTH);
	localparam int CW = $clog2(TPI_QUEUE_DEPTH + 1);

	q_item_t         slot_q [TPI_QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = count_q != CW'(TPI_QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(TPI_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(TPI_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: sv/tpi_table.sv
// Sample table in four interleaved banks, so four consecutive words are read together in one access.
`timescale 1ns / 1ps

module tpi_table import tpi_pkg::*; #(
	parameter int TABLE_WORDS = TPI_TABLE_WORDS
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [$clog2(TABLE_WORDS)-1:0] rd_index,
	input  logic                           wr_en,
	input  logic [$clog2(TABLE_WORDS)-1:0] wr_index,
	input  logic [TPI_WORD_W-1:0]          wr_data,
	output logic [TPI_WORD_W-1:0]          rd_word [4]
);

	localparam int AW   = $clog2(TABLE_WORDS);
	localparam int RW   = AW - 2;
	localparam int ROWS = (TABLE_WORDS + 3) / 4;

	logic [RW-1:0] base_row;
	logic [RW-1:0] base_row_inc;

	assign base_row     = rd_index[AW-1:2];
	assign base_row_inc = base_row + 1'b1;

	// Bank b holds addresses with b in the low two bits; banks below the start phase
	// read one row further on
	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [TPI_WORD_W-1:0] mem [ROWS];
		logic [TPI_WORD_W-1:0] rd_q;
		logic [RW-1:0]         row;

		assign row        = (2'(b) < rd_index[1:0]) ? base_row_inc : base_row;
		assign rd_word[b] = rd_q;

		always_ff @(posedge clk) begin
			if (wr_en && (wr_index[1:0] == 2'(b))) begin
				mem[wr_index[AW-1:2]] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[row];
			end
		end
	end

endmodule

// File: sv/tpi_back.sv
// Back pipeline: index split, table access, quadratic interpolation and slope.
`timescale 1ns / 1ps

module tpi_back import tpi_pkg::*; #(
	parameter int TABLE_WORDS = TPI_TABLE_WORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [TPI_WORD_W-1:0] inverse_step,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  q_item_t               item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	localparam int AW = $clog2(TABLE_WORDS);
	localparam logic [TPI_WORD_W-1:0] IDX_MAX = 32'(TABLE_WORDS - 4);
	localparam logic [TPI_WORD_W-1:0] WORDS   = 32'(TABLE_WORDS);
	localparam logic signed [36:0]    VAL_MAX = 37'sd2147483647;
	localparam logic signed [36:0]    VAL_MIN = -37'sd2147483648;

	// Stage valids and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	assign en_s8      = !vld_s8 || !out_stall;
	assign en_s7      = !vld_s7 || en_s8;
	assign en_s6      = !vld_s6 || en_s7;
	assign en_s5      = !vld_s5 || en_s6;
	assign en_s4      = !vld_s4 || en_s5;
	assign en_s3      = !vld_s3 || en_s4;
	assign en_s2      = !vld_s2 || en_s3;
	assign en_s1      = !vld_s1 || en_s2;
	assign item_ready = en_s1;

	// s1: scale offset by inverse_step
	logic [63:0]                  scaled;
	op_t                          op_s1;
	logic [TPI_WORD_W-1:0]        idx_raw_s1;
	logic [15:0]                  frac_s1;
	logic [TPI_INDEX_W-1:0]       waddr_s1;
	logic [TPI_WORD_W-1:0]        wdata_s1;

	assign scaled = 64'(item.offset) * 64'(inverse_step);

	// s2: saturate index, qualify write address
	logic                         sat;
	logic [AW-1:0]                idx;
	op_t                          op_s2;
	logic [AW-1:0]                idx_s2;
	logic [15:0]                  frac_s2;
	logic                         sat_s2;
	logic                         zero_s2;
	logic [AW-1:0]                waddr_s2;
	logic [TPI_WORD_W-1:0]        wdata_s2;
	logic                         wr_ok_s2;

	assign sat = idx_raw_s1 > IDX_MAX;
	assign idx = sat ? IDX_MAX[AW-1:0] : idx_raw_s1[AW-1:0];

	// s3: table read (data registered in the banks)
	logic [TPI_WORD_W-1:0]        rd_word [4];
	logic                         tbl_rd_en;
	logic                         tbl_wr_en;
	logic [1:0]                   phase_s3;
	logic [15:0]                  frac_s3;
	logic                         sat_s3;
	logic                         zero_s3;

	assign tbl_rd_en = en_s3 && vld_s2 && (op_s2 == OP_QUERY);
	assign tbl_wr_en = en_s3 && vld_s2 && (op_s2 == OP_WRITE) && wr_ok_s2;

	tpi_table #(
		.TABLE_WORDS (TABLE_WORDS)
	) u_table (
		.clk      (clk),
		.rd_en    (tbl_rd_en),
		.rd_index (idx_s2),
		.wr_en    (tbl_wr_en),
		.wr_index (waddr_s2),
		.wr_data  (wdata_s2),
		.rd_word  (rd_word)
	);

	// s4: order the four neighbors, form differences and curvature
	logic signed [31:0]           word_vm, word_v0, word_v1, word_v2;
	logic signed [32:0]           gi, gi1;
	logic signed [33:0]           curv, gdiff;
	logic signed [31:0]           v0_s4;
	logic signed [32:0]           gi_s4;
	logic signed [33:0]           gd_s4;
	logic signed [33:0]           curv_s4;
	logic [15:0]                  frac_s4;
	logic                         sat_s4;
	logic                         zero_s4;

	assign word_vm = rd_word[phase_s3];
	assign word_v0 = rd_word[phase_s3 + 2'd1];
	assign word_v1 = rd_word[phase_s3 + 2'd2];
	assign word_v2 = rd_word[phase_s3 + 2'd3];
	assign gi      = 33'(word_v1) - 33'(word_vm);
	assign gi1     = 33'(word_v2) - 33'(word_v0);
	assign curv    = 34'(word_v1) + 34'(word_vm) - (34'(word_v0) <<< 1);
	assign gdiff   = 34'(gi1) - 34'(gi);

	// s5: curvature and gradient change times fraction
	logic signed [16:0]           fs4;
	logic signed [50:0]           pcf, pgd;
	logic signed [50:0]           pcf_s5, pgd_s5;
	logic signed [32:0]           gi_s5;
	logic signed [31:0]           v0_s5;
	logic [15:0]                  frac_s5;
	logic                         sat_s5;
	logic                         zero_s5;

	assign fs4 = $signed({1'b0, frac_s4});
	assign pcf = curv_s4 * fs4;
	assign pgd = gd_s4 * fs4;

	// s6: round inner term and derivative, split derivative sign
	logic signed [51:0]           inner_sum, d_sum;
	logic signed [34:0]           d;
	logic signed [35:0]           inner_s6;
	logic [33:0]                  mag_s6;
	logic                         neg_s6;
	logic signed [31:0]           v0_s6;
	logic [15:0]                  frac_s6;
	logic                         sat_s6;
	logic                         zero_s6;

	assign inner_sum = 52'(pcf_s5) + (52'(gi_s5) <<< 16) + 52'sd32768;
	assign d_sum     = (52'(gi_s5) <<< 16) + 52'(pgd_s5) + 52'sd65536;
	assign d         = d_sum[51:17];

	// s7: inner times fraction, derivative magnitude times inverse_step halves
	logic signed [16:0]           fs6;
	logic signed [52:0]           pv;
	logic [49:0]                  pa, pb;
	logic signed [52:0]           pv_s7;
	logic [49:0]                  pa_s7, pb_s7;
	logic                         neg_s7;
	logic signed [31:0]           v0_s7;
	logic                         sat_s7;
	logic                         zero_s7;

	assign fs6 = $signed({1'b0, frac_s6});
	assign pv  = inner_s6 * fs6;
	assign pa  = mag_s6 * inverse_step[31:16];
	assign pb  = mag_s6 * inverse_step[15:0];

	// s8: final rounding and saturation into the output register
	logic signed [52:0]           pv_rnd;
	logic signed [35:0]           val_inc;
	logic signed [36:0]           val_full;
	logic [49:0]                  pb_rnd;
	logic [50:0]                  mag_prod;
	logic                         mag_big;
	out_item_t                    result;
	out_item_t                    out_s8;

	assign pv_rnd   = pv_s7 + 53'sd65536;
	assign val_inc  = pv_rnd[52:17];
	assign val_full = 37'(v0_s7) + 37'(val_inc);
	assign pb_rnd   = pb_s7 + 50'h8000;
	assign mag_prod = 51'(pa_s7) + 51'(pb_rnd[49:16]);
	assign mag_big  = mag_prod >= 51'h8000_0000;

	always_comb begin
		priority if (val_full > VAL_MAX) begin
			result.interpolated_value = 32'sh7FFF_FFFF;
		end else if (val_full < VAL_MIN) begin
			result.interpolated_value = 32'sh8000_0000;
		end else begin
			result.interpolated_value = val_full[31:0];
		end
		priority if (zero_s7) begin
			result.slope = '0;
		end else if (neg_s7) begin
			result.slope = mag_big ? 32'sh8000_0000 : -$signed(mag_prod[31:0]);
		end else begin
			result.slope = mag_big ? 32'sh7FFF_FFFF : $signed(mag_prod[31:0]);
		end
		result.index_saturated = sat_s7;
	end

	assign out_valid = vld_s8;
	assign out_data  = out_s8;

	// Valid chain; write items leave the pipeline at the table stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= item_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2 && (op_s2 == OP_QUERY);
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1      <= item.operation;
			idx_raw_s1 <= scaled[63:32];
			frac_s1    <= scaled[31:16];
			waddr_s1   <= item.entry_index;
			wdata_s1   <= item.entry_value;
		end
		if (en_s2) begin
			op_s2    <= op_s1;
			idx_s2   <= idx;
			frac_s2  <= frac_s1;
			sat_s2   <= sat;
			zero_s2  <= idx == '0;
			waddr_s2 <= AW'(waddr_s1);
			wdata_s2 <= wdata_s1;
			wr_ok_s2 <= 32'(waddr_s1) < WORDS;
		end
		if (en_s3) begin
			phase_s3 <= idx_s2[1:0];
			frac_s3  <= frac_s2;
			sat_s3   <= sat_s2;
			zero_s3  <= zero_s2;
		end
		if (en_s4) begin
			v0_s4   <= word_v0;
			gi_s4   <= gi;
			gd_s4   <= gdiff;
			curv_s4 <= curv;
			frac_s4 <= frac_s3;
			sat_s4  <= sat_s3;
			zero_s4 <= zero_s3;
		end
		if (en_s5) begin
			pcf_s5  <= pcf;
			pgd_s5  <= pgd;
			gi_s5   <= gi_s4;
			v0_s5   <= v0_s4;
			frac_s5 <= frac_s4;
			sat_s5  <= sat_s4;
			zero_s5 <= zero_s4;
		end
		if (en_s6) begin
			inner_s6 <= inner_sum[51:16];
			neg_s6   <= d[34];
			mag_s6   <= d[34] ? 34'(-d) : 34'(d);
			v0_s6    <= v0_s5;
			frac_s6  <= frac_s5;
			sat_s6   <= sat_s5;
			zero_s6  <= zero_s5;
		end
		if (en_s7) begin
			pv_s7   <= pv;
			pa_s7   <= pa;
			pb_s7   <= pb;
			neg_s7  <= neg_s6;
			v0_s7   <= v0_s6;
			sat_s7  <= sat_s6;
			zero_s7 <= zero_s6;
		end
		if (en_s8) begin
			out_s8 <= result;
		end
	end

endmodule

// File: sv/tabulated_potential_interpolator.sv
// Tabulated potential interpolator top level: config registers, front, queue and back pipeline.
// An accepted query passes the front register, the queue and back stages s1 to s8 before out_valid.
// Throughput: one item per cycle when nothing stalls; the four neighboring samples come from
// four interleaved banks in one read. Write items give no result but keep their place in order.
// Reset clears control state and config (inverse_step to 1.0); the sample table is not
// cleared and holds undefined data until written.
`timescale 1ns / 1ps

module tabulated_potential_interpolator import tpi_pkg::*; #(
	parameter int TABLE_WORDS = TPI_TABLE_WORDS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [TPI_CFG_INDEX_W-1:0] cfg_index,
	input  logic [TPI_WORD_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  in_item_t                   in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output out_item_t                  out_data
);

	logic signed [TPI_WORD_W-1:0] table_start_q;
	logic signed [TPI_WORD_W-1:0] table_end_q;
	logic [TPI_WORD_W-1:0]        inverse_step_q;

	logic    front_vld;
	q_item_t front_item;
	logic    q_ready;
	logic    q_valid;
	q_item_t q_item;
	logic    q_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_start_q  <= '0;
			table_end_q    <= '0;
			inverse_step_q <= TPI_INV_STEP_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_TABLE_START:  table_start_q  <= cfg_data;
				CFG_TABLE_END:    table_end_q    <= cfg_data;
				CFG_INVERSE_STEP: inverse_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tpi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.table_start (table_start_q),
		.table_end   (table_end_q),
		.item_valid  (front_vld),
		.item_ready  (q_ready),
		.item        (front_item)
	);

	tpi_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_vld),
		.push_ready (q_ready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_take),
		.pop_item   (q_item)
	);

	tpi_back #(
		.TABLE_WORDS (TABLE_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.inverse_step (inverse_step_q),
		.item_valid   (q_valid),
		.item_ready   (q_take),
		.item         (q_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

`ifndef SYNTH
	// A classified item waits in the front register until the queue takes it
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		front_vld && !q_ready |=> front_vld && $stable(front_item))
		else $error("front item lost or changed while queue full");

	// The queue only drains through a transfer into the back pipeline
	a_queue_keep: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && !q_take |=> q_valid)
		else $error("queue emptied without a transfer to the back pipeline");

	// Input stalls only when the front register is full and the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> front_vld && !q_ready)
		else $error("input stalled with room in front or queue");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the tabulated potential interpolator.
`timescale 1ns / 1ps

module tb;
	import tpi_pkg::*;

	localparam int TBL_WORDS = TPI_TABLE_WORDS;
	localparam int IMAX = TBL_WORDS - 4;
	// Entries filled at the bottom of the table; the top four are filled as well
	localparam int FILL_WORDS = 256;
	// Quiet cycles after the last result
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PER_PHASE = 146;
	localparam int NUM_PHASES = 8;
	localparam int PICK_TRIES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [TPI_CFG_INDEX_W-1:0] cfg_index = '0;
	logic [TPI_WORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	tabulated_potential_interpolator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// Items waiting to be driven, and lookups predicted but not yet seen
	in_item_t lookup_queue[$];
	out_item_t predicted_lookups[$];

	// Shadow copy of the block's table and registers
	logic [TPI_WORD_W-1:0] shadow_table [TBL_WORDS];
	logic signed [TPI_WORD_W-1:0] shadow_start = '0;
	logic signed [TPI_WORD_W-1:0] shadow_end = '0;
	logic [TPI_WORD_W-1:0] shadow_inv = TPI_INV_STEP_RESET;

	// Entries that some queued write has filled
	bit filled [TBL_WORDS];

	// Register values last programmed, used to aim distances
	logic signed [TPI_WORD_W-1:0] cur_start = '0;
	logic signed [TPI_WORD_W-1:0] cur_end = '0;
	logic [TPI_WORD_W-1:0] cur_inv = TPI_INV_STEP_RESET;

	int mismatches = 0;
	int cycle_count = 0;
	logic in_took = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic signed [TPI_WORD_W-1:0] clip_word(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[TPI_WORD_W-1:0];
	endfunction

	// Quadratic interpolation and slope at one distance, from the shadow state
	function automatic out_item_t interp_predict(logic signed [TPI_WORD_W-1:0] query_dist);
		longint r, diff, idx, frac;
		longint vm, v0, v1, v2, gi, gi1, curv, inner, val, d, res;
		longint unsigned prod, mag;
		logic neg, hit_top;
		out_item_t o;
		idx = 0;
		frac = 0;
		hit_top = 1'b0;
		r = query_dist;
		if (r < shadow_start)
			r = shadow_start;
		else if (r > shadow_end)
			r = shadow_end;
		diff = r - longint'(shadow_start);
		if (diff > 0) begin
			prod = longint'(diff) * longint'({32'd0, shadow_inv});
			idx = longint'(prod >> 32);
			frac = longint'((prod >> 16) & 64'hFFFF);
		end
		if (idx > IMAX) begin
			idx = IMAX;
			hit_top = 1'b1;
		end
		vm = longint'(signed'(shadow_table[idx]));
		v0 = longint'(signed'(shadow_table[idx + 1]));
		v1 = longint'(signed'(shadow_table[idx + 2]));
		v2 = longint'(signed'(shadow_table[idx + 3]));
		gi = v1 - vm;
		gi1 = v2 - v0;
		curv = v1 + vm - 2 * v0;
		// round half up: add half, then arithmetic shift
		inner = (curv * frac + gi * 64'sd65536 + 64'sd32768) >>> 16;
		val = v0 + ((inner * frac + 64'sd65536) >>> 17);
		if (idx == 0) begin
			res = 0;
		end else begin
			d = (gi * 64'sd65536 + frac * (gi1 - gi) + 64'sd65536) >>> 17;
			neg = (d < 0);
			mag = neg ? longint'(-d) : longint'(d);
			prod = mag * longint'(shadow_inv >> 16) +
				((mag * longint'(shadow_inv & 32'h0000_FFFF) + 64'd32768) >> 16);
			if (prod > 64'h8000_0000)
				prod = 64'h8000_0000;
			res = neg ? -longint'(prod) : longint'(prod);
		end
		o.interpolated_value = clip_word(val);
		o.slope = clip_word(res);
		o.index_saturated = hit_top;
		return o;
	endfunction

	// True when the four entries a lookup reads have all been filled
	function automatic bit lookup_ok(logic signed [TPI_WORD_W-1:0] query_dist);
		longint r, diff;
		longint unsigned prod, idx;
		idx = 0;
		r = query_dist;
		if (r < cur_start)
			r = cur_start;
		else if (r > cur_end)
			r = cur_end;
		diff = r - longint'(cur_start);
		if (diff > 0) begin
			prod = longint'(diff) * longint'({32'd0, cur_inv});
			idx = prod >> 32;
		end
		if (idx > IMAX)
			idx = IMAX;
		return filled[idx] && filled[idx + 1] && filled[idx + 2] && filled[idx + 3];
	endfunction

	// Table sample with extremes and small values mixed in
	function automatic logic [TPI_WORD_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom();
		endcase
	endfunction

	// Distance aimed at the programmed range, its edges and beyond
	function automatic logic [TPI_WORD_W-1:0] pick_distance();
		longint lo, hi, span;
		longint unsigned rnd;
		lo = cur_start;
		hi = cur_end;
		if (hi < lo) begin
			lo = cur_end;
			hi = cur_start;
		end
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 5))
					0: return cur_start;
					1: return cur_end;
					2: return cur_start - 1;
					3: return cur_end + 1;
					4: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			2, 3: return cur_start + $urandom_range(0, 8191);
			default: begin
				span = hi - lo + 1;
				rnd = {$urandom(), $urandom()};
				return TPI_WORD_W'(lo + longint'(rnd % longint'(span)));
			end
		endcase
	endfunction

	task automatic queue_write(input logic [TPI_INDEX_W-1:0] addr,
			input logic [TPI_WORD_W-1:0] value);
		in_item_t it;
		it.operation = OP_WRITE;
		it.entry_index = addr;
		it.entry_value = value;
		it.distance = $urandom();
		lookup_queue.push_back(it);
		filled[addr] = 1'b1;
	endtask

	task automatic queue_query(input logic [TPI_WORD_W-1:0] query_dist);
		in_item_t it;
		it.operation = OP_QUERY;
		it.entry_index = TPI_INDEX_W'($urandom());
		it.entry_value = $urandom();
		it.distance = query_dist;
		lookup_queue.push_back(it);
	endtask

	// Wait until every item is in and every lookup is back, then let the pipe empty
	task automatic drain();
		while (lookup_queue.size() != 0 || in_valid || predicted_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_bounds(input logic [TPI_WORD_W-1:0] t_start,
			input logic [TPI_WORD_W-1:0] t_end, input logic [TPI_WORD_W-1:0] inv);
		cur_start = t_start;
		cur_end = t_end;
		cur_inv = inv;
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_TABLE_START;
		cfg_data <= t_start;
		@(negedge clk);
		cfg_index <= CFG_TABLE_END;
		cfg_data <= t_end;
		@(negedge clk);
		cfg_index <= CFG_INVERSE_STEP;
		cfg_data <= inv;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stimulus: table fill, directed cases, then random phases
	initial begin
		logic [TPI_WORD_W-1:0] ph_start [NUM_PHASES];
		logic [TPI_WORD_W-1:0] ph_end [NUM_PHASES];
		logic [TPI_WORD_W-1:0] ph_inv [NUM_PHASES];
		logic [TPI_WORD_W-1:0] qd;
		ph_start = '{32'h0000_8000, 32'h8000_0000, 32'h0000_0000, 32'h03E8_0000,
			32'hFF9C_0000, 32'h1234_5678, 32'h0000_0000, 32'h7FFF_FFFF};
		ph_end = '{32'h0040_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFC18_0000,
			32'h0064_0000, 32'h1234_5678, 32'h00FC_0000, 32'h8000_0000};
		ph_inv = '{32'h0003_F000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0004_0000,
			32'h0001_4000, 32'h0000_0000, 32'h0001_0000, 32'h8000_0000};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bottom of the table and the top four entries; lookups stay on filled entries
		for (int a = 0; a < FILL_WORDS; a++)
			queue_write(TPI_INDEX_W'(a), pick_sample());
		for (int a = IMAX; a < TBL_WORDS; a++)
			queue_write(TPI_INDEX_W'(a), pick_sample());
		// Reset bounds: everything clamps to index zero
		queue_query(32'h8000_0000);
		queue_query(32'h7FFF_FFFF);
		queue_query(32'h0000_0000);
		drain();

		// Step 1.0 over the whole table: index zero, fractions, top of table
		program_bounds(32'h0000_0000, 32'h0FFF_0000, 32'h0001_0000);
		queue_write(12'd0, 32'h7FFF_FFFF);
		queue_write(12'd1, 32'h7FFF_FFFF);
		queue_write(12'd2, 32'h8000_0000);
		queue_write(12'hFFF, 32'h8000_0000);
		queue_query(32'h0000_0000);
		queue_query(32'h0000_8000);
		queue_query(32'h0000_FFFF);
		queue_query(32'h0001_0000);
		queue_query(32'h0001_8000);
		queue_query(32'h0FFC_0000);
		queue_query(32'h0FFC_8000);
		queue_query(32'h0FFD_0000);
		queue_query(32'h7FFF_FFFF);
		queue_query(32'h8000_0000);
		drain();

		// Inverted bounds: above the end gives a negative offset
		program_bounds(32'h0064_0000, 32'hFF9C_0000, 32'h0010_0000);
		queue_query(32'hFF9C_0001);
		queue_query(32'h0064_0000);
		queue_query(32'h8000_0000);
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			program_bounds(ph_start[p], ph_end[p], ph_inv[p]);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < 15) begin
					queue_write(TPI_INDEX_W'($urandom()), pick_sample());
				end else begin
					qd = pick_distance();
					for (int t = 0; t < PICK_TRIES && !lookup_ok(qd); t++)
						qd = pick_distance();
					// the start of the range always lands on index zero
					if (!lookup_ok(qd))
						qd = cur_start;
					queue_query(qd);
				end
			end
			drain();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Sender: bursts of transfers with random gaps
	always @(negedge clk) begin
		logic nv;
		in_item_t nd;
		nv = in_valid;
		nd = in_data;
		if (arst_n && !(in_valid && !in_took)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (lookup_queue.size() > 0) begin
				nd = lookup_queue.pop_front();
				nv = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		in_valid <= nv;
		in_data <= nd;
	end

	// Receiver: stall pattern switching between free, random, heavy and solid stretches
	always @(negedge clk) begin
		logic ns;
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = (stall_mode == 3) ? $urandom_range(1, 30) : $urandom_range(20, 200);
		end
		stall_left--;
		case (stall_mode)
			0: ns = 1'b0;
			1: ns = 1'($urandom_range(0, 1));
			2: ns = ($urandom_range(0, 4) != 0);
			default: ns = 1'b1;
		endcase
		out_stall <= ns;
	end

	// Prediction on accepted items, checking of accepted results
	always @(posedge clk) begin
		out_item_t want;
		in_took = arst_n && in_valid && !in_stall;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_TABLE_START: shadow_start = cfg_data;
					CFG_TABLE_END: shadow_end = cfg_data;
					CFG_INVERSE_STEP: shadow_inv = cfg_data;
					default: ;
				endcase
			end
			if (in_took) begin
				if (in_data.operation == OP_WRITE)
					shadow_table[in_data.entry_index] = in_data.entry_value;
				else
					predicted_lookups.push_back(interp_predict(in_data.distance));
			end
			if (out_valid && !out_stall) begin
				if (predicted_lookups.size() == 0) begin
					$error("unexpected result transfer");
					mismatches++;
				end else begin
					want = predicted_lookups.pop_front();
					if (out_data.interpolated_value !== want.interpolated_value) begin
						$error("interpolated_value: expected %0d, got %0d",
							want.interpolated_value, out_data.interpolated_value);
						mismatches++;
					end
					if (out_data.slope !== want.slope) begin
						$error("slope: expected %0d, got %0d", want.slope, out_data.slope);
						mismatches++;
					end
					if (out_data.index_saturated !== want.index_saturated) begin
						$error("index_saturated: expected %0d, got %0d",
							want.index_saturated, out_data.index_saturated);
						mismatches++;
					end
				end
			end
		end
	end

endmodule
